// File: src/gdfw_pkg.sv
// Shared types, codes and default sizes for the depth-first graph walker.
`timescale 1ns / 1ps

package gdfw_pkg;

    localparam int VERTEX_W         = 4;
    localparam int MAX_RESULTS      = 16;
    localparam int RESULT_CW        = $clog2(MAX_RESULTS + 1);
    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_MAX_ENTRIES  = 128;
    localparam int DEF_STACK_DEPTH  = 16;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_WALK     = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_NEW_A,
        ST_ADD_LINK_A,
        ST_ADD_NEW_B,
        ST_ADD_LINK_B,
        ST_WALK_TOP,
        ST_WALK_READ,
        ST_FINISH
    } state_t;

    // Enables of the entry memory ports
    typedef struct packed {
        logic target_we;
        logic link_we;
        logic rd_en;
    } mem_ctl_t;

endpackage

// File: src/gdfw_entry_mem.sv
// Adjacency entry memory: target vertex and next-entry link, registered read.
`timescale 1ns / 1ps

module gdfw_entry_mem #(
    parameter int MAX_ENTRIES = gdfw_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                clk,
    input  gdfw_pkg::mem_ctl_t                  ctl,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      wr_addr,
    input  logic [gdfw_pkg::VERTEX_W-1:0]       wr_target,
    input  logic                                wr_link_valid,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      wr_link,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      rd_addr,
    output logic [gdfw_pkg::VERTEX_W-1:0]       rd_target,
    output logic                                rd_link_valid,
    output logic [$clog2(MAX_ENTRIES)-1:0]      rd_link
);
    import gdfw_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    logic [VERTEX_W-1:0] target_mem [MAX_ENTRIES];
    logic [AW:0]         link_mem   [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (ctl.target_we)
        begin
            target_mem[wr_addr] <= wr_target;
        end
        if (ctl.link_we)
        begin
            link_mem[wr_addr] <= {wr_link_valid, wr_link};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_target                <= target_mem[rd_addr];
            {rd_link_valid, rd_link} <= link_mem[rd_addr];
        end
    end

endmodule

// File: src/graph_depth_first_walk.sv
// Top level of the depth-first graph walker: command decode, walk sequencer and output stage.
`timescale 1ns / 1ps
//
// Usage: items enter on the s_axis group; s_axis_tuser is the command (0 add
// edge, 1 walk), s_axis_tdata carries the two vertices. Results leave on the
// m_axis group: m_axis_tdata is the vertex, m_axis_tuser the status and
// m_axis_tlast marks the final result of the item.
// One item is worked on at a time; s_axis_tready is high only while idle.
// An edge add passes through the states ADD_NEW_A, ADD_LINK_A, ADD_NEW_B
// and ADD_LINK_B before its result; a full table or an out-of-range vertex
// answers straight from idle. A walk reads each adjacency entry through the
// entry memory read port in WALK_TOP and WALK_READ; a stack pop takes only
// WALK_TOP, and FINISH ends the walk.
// Each result is held one step in a pending register so that the final one
// can be flagged; it reaches the output register when the next one appears
// or the item ends. A stalled receiver holds the output register and the
// walk waits at its next result. Reset empties all adjacency lists and the
// entry count at once; no clearing pass is needed.
//
module graph_depth_first_walk #(
    parameter int MAX_VERTICES = gdfw_pkg::DEF_MAX_VERTICES,
    parameter int MAX_ENTRIES  = gdfw_pkg::DEF_MAX_ENTRIES,
    parameter int STACK_DEPTH  = gdfw_pkg::DEF_STACK_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // first_vertex[3:0], second_vertex[7:4]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // vertex[3:0], zero[7:4]
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);
    import gdfw_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // State and datapath registers
    state_t                 state_reg, state_next;
    logic [VERTEX_W-1:0]    edge_a_reg, edge_b_reg;
    logic [CW-1:0]          entry_count_reg;
    logic [AW-1:0]          list_head_reg [MAX_VERTICES];
    logic [AW-1:0]          list_tail_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] head_valid_reg;
    logic [MAX_VERTICES-1:0] seen_reg;
    logic [VERTEX_W-1:0]    stack_vertex_reg [STACK_DEPTH];
    logic [AW-1:0]          stack_cursor_reg [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] stack_cv_reg;
    logic [DW-1:0]          walk_depth_reg;
    logic [RESULT_CW-1:0]   result_count_reg;
    logic                   pend_valid_reg;
    logic [VERTEX_W-1:0]    pend_vertex_reg;
    status_t                pend_status_reg;
    logic                   out_valid_reg;
    logic [VERTEX_W-1:0]    out_vertex_reg;
    status_t                out_status_reg;
    logic                   out_last_reg;

    // Entry memory interface
    mem_ctl_t               mem_ctl;
    logic [AW-1:0]          wr_addr, wr_link, rd_addr, rd_link;
    logic [VERTEX_W-1:0]    wr_target, rd_target;
    logic                   wr_link_valid, rd_link_valid;

    // Decoded inputs and control
    logic [VERTEX_W-1:0]    in_a, in_b;
    logic                   in_a_ok, in_b_ok, table_full;
    logic [CW:0]            count_plus2;
    logic [VERTEX_W-1:0]    owner, other;
    logic [VW-1:0]          owner_idx, w_idx, push_v_idx;
    logic [AW-1:0]          append_e;
    logic [SW-1:0]          top_idx, push_idx;
    logic                   w_ok, slot_free, can_emit;
    logic                   append_en, walk_start, push_en, pop_en, cursor_en, seen_en;
    logic                   emit_en, finish_en, out_load, count_en;
    logic [VERTEX_W-1:0]    emit_vertex, push_vertex;
    status_t                emit_status;

    assign in_a        = s_axis_tdata[3:0];
    assign in_b        = s_axis_tdata[7:4];
    assign in_a_ok     = 32'(in_a) < MAX_VERTICES;
    assign in_b_ok     = 32'(in_b) < MAX_VERTICES;
    assign count_plus2 = {1'b0, entry_count_reg} + (CW + 1)'(2);
    assign table_full  = count_plus2 > (CW + 1)'(MAX_ENTRIES);

    assign owner       = (state_reg == ST_ADD_NEW_A || state_reg == ST_ADD_LINK_A)
                         ? edge_a_reg : edge_b_reg;
    assign other       = (state_reg == ST_ADD_NEW_A || state_reg == ST_ADD_LINK_A)
                         ? edge_b_reg : edge_a_reg;
    assign owner_idx   = VW'(owner);
    assign append_e    = entry_count_reg[AW-1:0];

    assign top_idx     = SW'(walk_depth_reg - DW'(1));
    assign w_idx       = VW'(rd_target);
    assign w_ok        = (32'(rd_target) < MAX_VERTICES) && !seen_reg[w_idx];
    assign slot_free   = !out_valid_reg || m_axis_tready;
    assign can_emit    = !pend_valid_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        mem_ctl       = '0;
        wr_addr       = append_e;
        wr_target     = other;
        wr_link_valid = 1'b0;
        wr_link       = '0;
        rd_addr       = stack_cursor_reg[top_idx];
        append_en     = 1'b0;
        walk_start    = 1'b0;
        push_en       = 1'b0;
        push_vertex   = rd_target;
        pop_en        = 1'b0;
        cursor_en     = 1'b0;
        seen_en       = 1'b0;
        emit_en       = 1'b0;
        emit_vertex   = '0;
        emit_status   = STATUS_OK;
        count_en      = 1'b0;
        finish_en     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == CMD_ADD_EDGE)
                    begin
                        if (in_a_ok && in_b_ok && !table_full)
                        begin
                            state_next = ST_ADD_NEW_A;
                        end
                        else
                        begin
                            // Out-of-range vertices answer OK with nothing stored
                            emit_en     = 1'b1;
                            emit_status = (in_a_ok && in_b_ok) ? STATUS_FULL : STATUS_OK;
                            state_next  = ST_FINISH;
                        end
                    end
                    else if (in_a_ok)
                    begin
                        walk_start  = 1'b1;
                        push_en     = 1'b1;
                        push_vertex = in_a;
                        emit_en     = 1'b1;
                        emit_vertex = in_a;
                        state_next  = ST_WALK_TOP;
                    end
                end
            end
            ST_ADD_NEW_A, ST_ADD_NEW_B:
            begin
                // Store the new entry, end of list so far
                mem_ctl.target_we = 1'b1;
                mem_ctl.link_we   = 1'b1;
                state_next        = (state_reg == ST_ADD_NEW_A) ? ST_ADD_LINK_A
                                                                : ST_ADD_LINK_B;
            end
            ST_ADD_LINK_A, ST_ADD_LINK_B:
            begin
                // Chain the new entry behind the owner's old tail
                append_en       = 1'b1;
                mem_ctl.link_we = head_valid_reg[owner_idx];
                wr_addr         = list_tail_reg[owner_idx];
                wr_link_valid   = 1'b1;
                wr_link         = append_e;
                if (state_reg == ST_ADD_LINK_A)
                begin
                    state_next = ST_ADD_NEW_B;
                end
                else
                begin
                    emit_en    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_WALK_TOP:
            begin
                if (walk_depth_reg == '0 || result_count_reg >= RESULT_CW'(MAX_RESULTS))
                begin
                    state_next = ST_FINISH;
                end
                else if (!stack_cv_reg[top_idx])
                begin
                    pop_en = 1'b1;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = ST_WALK_READ;
                end
            end
            ST_WALK_READ:
            begin
                if (!w_ok)
                begin
                    cursor_en  = 1'b1;
                    state_next = ST_WALK_TOP;
                end
                else if (32'(walk_depth_reg) >= STACK_DEPTH)
                begin
                    if (can_emit)
                    begin
                        emit_en     = 1'b1;
                        emit_status = STATUS_OVERFLOW;
                        count_en    = 1'b1;
                        state_next  = ST_FINISH;
                    end
                end
                else if (can_emit)
                begin
                    cursor_en   = 1'b1;
                    seen_en     = 1'b1;
                    push_en     = 1'b1;
                    emit_en     = 1'b1;
                    emit_vertex = rd_target;
                    count_en    = 1'b1;
                    state_next  = ST_WALK_TOP;
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    finish_en  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_load   = (emit_en && pend_valid_reg) || finish_en;
    assign push_idx   = walk_start ? '0 : SW'(walk_depth_reg);
    assign push_v_idx = VW'(push_vertex);

    gdfw_entry_mem #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_entry_mem (
        .clk           (clk),
        .ctl           (mem_ctl),
        .wr_addr       (wr_addr),
        .wr_target     (wr_target),
        .wr_link_valid (wr_link_valid),
        .wr_link       (wr_link),
        .rd_addr       (rd_addr),
        .rd_target     (rd_target),
        .rd_link_valid (rd_link_valid),
        .rd_link       (rd_link)
    );

    // Latch edge endpoints
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            edge_a_reg <= in_a;
            edge_b_reg <= in_b;
        end
    end

    // Adjacency list heads and tails
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= '0;
            entry_count_reg <= '0;
        end
        else if (append_en)
        begin
            head_valid_reg[owner_idx] <= 1'b1;
            entry_count_reg           <= entry_count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (append_en)
        begin
            list_tail_reg[owner_idx] <= append_e;
            if (!head_valid_reg[owner_idx])
            begin
                list_head_reg[owner_idx] <= append_e;
            end
        end
    end

    // Walk stack payload
    always_ff @(posedge clk)
    begin
        if (cursor_en)
        begin
            stack_cursor_reg[top_idx] <= rd_link;
            stack_cv_reg[top_idx]     <= rd_link_valid;
        end
        if (push_en)
        begin
            stack_vertex_reg[push_idx] <= push_vertex;
            stack_cursor_reg[push_idx] <= list_head_reg[push_v_idx];
            stack_cv_reg[push_idx]     <= head_valid_reg[push_v_idx];
        end
    end

    // Walk control: depth, seen map, result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_depth_reg   <= '0;
            seen_reg         <= '0;
            result_count_reg <= '0;
        end
        else
        begin
            if (walk_start)
            begin
                walk_depth_reg   <= DW'(1);
                result_count_reg <= RESULT_CW'(1);
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    seen_reg[i] <= (i == 32'(in_a));
                end
            end
            else
            begin
                if (push_en)
                begin
                    walk_depth_reg <= walk_depth_reg + DW'(1);
                end
                else if (pop_en)
                begin
                    walk_depth_reg <= walk_depth_reg - DW'(1);
                end
                if (seen_en)
                begin
                    seen_reg[w_idx] <= 1'b1;
                end
                if (count_en)
                begin
                    result_count_reg <= result_count_reg + RESULT_CW'(1);
                end
            end
        end
    end

    // Pending result and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit_en)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (finish_en)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            pend_vertex_reg <= emit_vertex;
            pend_status_reg <= emit_status;
        end
        if (out_load)
        begin
            out_vertex_reg <= pend_vertex_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= finish_en;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_vertex_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // The stack never grows past its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(walk_depth_reg) <= STACK_DEPTH)
        else $error("walk stack depth beyond limit");

    // The entry table never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(entry_count_reg) <= MAX_ENTRIES)
        else $error("entry count beyond table size");

    // Nothing is left pending once idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending result left behind at idle");

    // A result is never loaded over one the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("output register overwritten");

    // Each walk stops within the result limit
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(result_count_reg) <= MAX_RESULTS)
        else $error("result count beyond limit");

    // The top of stack is always in use when its entry is read
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.rd_en |-> walk_depth_reg != '0)
        else $error("entry read with an empty stack");

endmodule
